@@ design/assert_macros.svh @@
// Assertion macros for the design files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/qsft_pkg.sv @@
// Types, constants and saturation helper for the state-feedback thrust block.
package qsft_pkg;

    localparam int FX_W           = 8;
    localparam int FRAC_BITS      = 4;
    localparam int NUM_STATES     = 12;
    localparam int NUM_REFS       = 6;
    localparam int NUM_ACT        = 4;
    localparam int NUM_GAIN_WORDS = 6;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_ADDR_W     = 3;
    localparam int REF_W          = NUM_REFS * FX_W;
    localparam int ROW_GAIN_W     = NUM_STATES * FX_W;
    localparam int GAIN_W         = NUM_GAIN_WORDS * CFG_DATA_W;
    localparam int PROD_W         = 2 * FX_W;
    // 12 products of at most 2^14 in magnitude fit in 19 signed bits
    localparam int ACC_W          = 19;
    localparam int IN_DATA_W      = NUM_STATES * FX_W;
    localparam int OUT_DATA_W     = NUM_ACT * FX_W;
    localparam int FX_MAX         = (1 << (FX_W - 1)) - 1;
    localparam int FX_MIN         = -(1 << (FX_W - 1));

    typedef logic signed [FX_W-1:0] fx_t;
    typedef logic [NUM_STATES-1:0][FX_W-1:0] fx_vec_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REF    = 3'd0,
        CFG_GAIN0  = 3'd1,
        CFG_GAIN1  = 3'd2,
        CFG_GAIN2  = 3'd3,
        CFG_GAIN3  = 3'd4,
        CFG_GAIN4  = 3'd5,
        CFG_GAIN5  = 3'd6,
        CFG_OFFSET = 3'd7
    } cfg_reg_e;

    localparam fx_t OFFSET_RESET = 8'sd52;

    // Clip a one-bit-wider signed value to the word range.
    function automatic fx_t sat_fx(input logic signed [FX_W:0] v);
        fx_t r;
        if (v > (FX_W + 1)'(FX_MAX)) begin
            r = fx_t'(FX_MAX);
        end else if (v < (FX_W + 1)'(FX_MIN)) begin
            r = fx_t'(FX_MIN);
        end else begin
            r = v[FX_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/quantized_state_feedback_thrust.sv @@
// Top level: config registers, error stage register, thrust result register.
//
//  channel  dir  word                                 accepted when
//  s_       in   12 x Q4.4 state, pos_x at bits 7:0   s_tvalid & s_tready
//  m_       out  4 x Q4.4 thrust, thrust_1 at 7:0     m_tvalid & m_tready
//  cfg_     in   register index + 64-bit value        cfg_wr_en
//
// Two register stages: the error vector is registered at accept, the four dot
// products are computed from it and registered into the output register; one
// word per cycle sustained while m_tready holds. Each stage advances when the
// stage behind it is empty or moving, so a stalled output still leaves room for
// one more word. Reset clears both valid flags and loads the register defaults.
`include "assert_macros.svh"

module quantized_state_feedback_thrust (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
    // vel_x, vel_y, vel_z, rate_x, rate_y, rate_z
    input  logic [qsft_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // thrust_1, thrust_2, thrust_3, thrust_4
    output logic [qsft_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [qsft_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [qsft_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import qsft_pkg::*;

    logic [REF_W-1:0]      ref_reg;
    logic [CFG_DATA_W-1:0] gain_reg [NUM_GAIN_WORDS];
    fx_t                   offset_reg;
    logic [GAIN_W-1:0]     gains_flat;

    logic                  st1_valid_reg;
    fx_vec_t               err_reg;
    fx_vec_t               err_next;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] out_reg;
    logic [OUT_DATA_W-1:0] out_next;

    logic                  out_ready;
    logic                  st1_ready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg    <= '0;
            offset_reg <= OFFSET_RESET;
            for (int w = 0; w < NUM_GAIN_WORDS; w++) begin
                gain_reg[w] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_e'(cfg_addr))
                CFG_REF: begin
                    ref_reg <= cfg_wdata[REF_W-1:0];
                end
                CFG_GAIN0, CFG_GAIN1, CFG_GAIN2, CFG_GAIN3, CFG_GAIN4, CFG_GAIN5: begin
                    gain_reg[CFG_ADDR_W'(cfg_addr - CFG_ADDR_W'(CFG_GAIN0))] <= cfg_wdata;
                end
                CFG_OFFSET: begin
                    offset_reg <= cfg_wdata[FX_W-1:0];
                end
            endcase
        end
    end

    always_comb begin
        for (int w = 0; w < NUM_GAIN_WORDS; w++) begin
            gains_flat[w*CFG_DATA_W +: CFG_DATA_W] = gain_reg[w];
        end
    end

    // handshake
    assign out_ready = !m_valid_reg || m_tready;
    assign st1_ready = !st1_valid_reg || out_ready;
    assign s_tready  = st1_ready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_reg;

    qsft_err u_err (
        .ref_setpoint (ref_reg),
        .state        (fx_vec_t'(s_tdata)),
        .err          (err_next)
    );

    for (genvar r = 0; r < NUM_ACT; r++) begin : g_row
        fx_t thrust;

        qsft_row u_row (
            .gains  (gains_flat[r*ROW_GAIN_W +: ROW_GAIN_W]),
            .err    (err_reg),
            .offset (offset_reg),
            .thrust (thrust)
        );

        assign out_next[r*FX_W +: FX_W] = thrust;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                m_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && st1_ready) begin
            err_reg <= err_next;
        end
        if (out_ready && st1_valid_reg) begin
            out_reg <= out_next;
        end
    end

    `ASSERT_IMPL(a_empty_stage_ready, aclk, aresetn, !st1_valid_reg, s_tready, "empty stage not ready")
    `ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_tvalid && s_tready, st1_valid_reg, "word lost at input")
    `ASSERT_NEXT(a_stage_moves, aclk, aresetn, st1_valid_reg && out_ready, m_valid_reg, "word lost between stages")

endmodule

@@ design/qsft_err.sv @@
// Error vector: reference minus state, saturated, for every state element.
module qsft_err (
    input  logic [qsft_pkg::REF_W-1:0] ref_setpoint,
    input  qsft_pkg::fx_vec_t          state,
    output qsft_pkg::fx_vec_t          err
);
    import qsft_pkg::*;

    for (genvar c = 0; c < NUM_STATES; c++) begin : g_elem
        fx_t                    ref_c;
        fx_t                    st_c;
        logic signed [FX_W:0]   diff;

        // velocity and rate elements regulate to zero
        if (c < NUM_REFS) begin : g_ref
            assign ref_c = ref_setpoint[c*FX_W +: FX_W];
        end else begin : g_zero
            assign ref_c = '0;
        end

        assign st_c   = state[c];
        assign diff   = $signed({ref_c[FX_W-1], ref_c}) - $signed({st_c[FX_W-1], st_c});
        assign err[c] = sat_fx(diff);
    end

endmodule

@@ design/qsft_row.sv @@
// One thrust output: gain row dot error vector, rounded, saturated, plus hover offset.
module qsft_row (
    input  logic [qsft_pkg::ROW_GAIN_W-1:0] gains,
    input  qsft_pkg::fx_vec_t               err,
    input  qsft_pkg::fx_t                   offset,
    output qsft_pkg::fx_t                   thrust
);
    import qsft_pkg::*;

    localparam int Q_W  = ACC_W - FRAC_BITS;
    localparam int HALF = 1 << (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod [NUM_STATES];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [Q_W-1:0]    q;
    fx_t                      q_sat;
    logic signed [FX_W:0]     biased;

    for (genvar c = 0; c < NUM_STATES; c++) begin : g_mul
        assign prod[c] = $signed(gains[c*FX_W +: FX_W]) * $signed(err[c]);
    end

    always_comb begin
        acc = '0;
        for (int c = 0; c < NUM_STATES; c++) begin
            acc = acc + ACC_W'(prod[c]);
        end
    end

    // half away from zero: +HALF for positive, +HALF-1 for negative, then floor shift
    assign rnd = acc + (acc[ACC_W-1] ? ACC_W'(HALF - 1) : ACC_W'(HALF));
    assign q   = $signed(rnd[ACC_W-1:FRAC_BITS]);

    always_comb begin
        if (q > Q_W'(FX_MAX)) begin
            q_sat = fx_t'(FX_MAX);
        end else if (q < Q_W'(FX_MIN)) begin
            q_sat = fx_t'(FX_MIN);
        end else begin
            q_sat = q[FX_W-1:0];
        end
    end

    assign biased = $signed({q_sat[FX_W-1], q_sat}) + $signed({offset[FX_W-1], offset});
    assign thrust = sat_fx(biased);

endmodule
